### rtl/variable_length_record_ring_fifo_assert.svh
// Assertion macros for the variable-length record ring FIFO.
`ifndef VARIABLE_LENGTH_RECORD_RING_FIFO_ASSERT_SVH
`define VARIABLE_LENGTH_RECORD_RING_FIFO_ASSERT_SVH
`ifndef SYNTH
`define VLRF_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("vlrf assertion failed");
`define VLRF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("vlrf assertion failed");
`else
`define VLRF_ASSERT_NOW(label, ante, cons)
`define VLRF_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### rtl/vlrf_pkg.sv
// Types and codes shared by the record ring FIFO files.
package vlrf_pkg;

	typedef logic [7:0] byte_t;

	typedef enum logic [1:0] {
		CMD_PUSH   = 2'd0,
		CMD_POP    = 2'd1,
		CMD_PEEK   = 2'd2,
		CMD_IGNORE = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NOROOM   = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_MISMATCH = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_HDR_WR,
		S_DATA_WR,
		S_HDR_RD,
		S_HDR_ACC,
		S_HDR_CHK,
		S_RD_DATA,
		S_EMIT
	} state_t;

endpackage

### rtl/variable_length_record_ring_fifo.sv
// Top level of the variable-length record ring FIFO with its sequencer.
//
//   channel   handshake              payload
//   command   cmd_valid / cmd_ready  command, data_byte, record_length
//   result    rsp_valid / rsp_ready  status, out_byte, byte_valid, last,
//                                    empty_flag, free_bytes
//
// A push byte writes its byte to the ring, after the LENGTH_BYTES header bytes on the first
// byte of a record (only the header for a zero-length record); a dropped byte or command 3
// writes nothing. A pop or peek reads and checks the header, then returns one result per
// record byte or a single result; on an empty queue it returns a single result.
// Reset clears pointers and counts at once; the ring needs no clearing.
// A stalled result holds the sequencer; cmd_ready is high only when idle.
`include "variable_length_record_ring_fifo_assert.svh"

module variable_length_record_ring_fifo #(
	parameter int RING_BYTES   = 256,
	parameter int MAX_RECORD   = 64,
	parameter int LENGTH_BYTES = 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_ready,
	input  vlrf_pkg::cmd_t      command,
	input  logic [7:0]          data_byte,
	input  logic [6:0]          record_length,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output vlrf_pkg::status_t   status,
	output logic [7:0]          out_byte,
	output logic                byte_valid,
	output logic                last,
	output logic                empty_flag,
	output logic [8:0]          free_bytes
);
	import vlrf_pkg::*;

	localparam int PW  = (RING_BYTES > 1) ? $clog2(RING_BYTES) : 1;
	localparam int FW  = $clog2(RING_BYTES + 1);
	localparam int CW  = ((FW > 8) ? FW : 8) + 1;
	localparam int LKW = (LENGTH_BYTES > 1) ? $clog2(LENGTH_BYTES) : 1;

	function automatic logic [PW-1:0] ring_inc(input logic [PW-1:0] p);
		return (p == PW'(RING_BYTES - 1)) ? '0 : p + PW'(1);
	endfunction

	state_t        state_q, state_d;
	logic [PW-1:0] rp_q, cp_q, wp_q, cur_q;
	logic [FW-1:0] free_q, count_q;
	logic [6:0]    progress_q, push_len_q, len_q, hdr_len_q, rem_q;
	logic          dropping_q, hdr_hi_q, pop_q;
	logic [LKW-1:0] hk_q;
	byte_t         byte_q;
	status_t       res_status_q;

	logic          accept, slot_free, no_room, hk_last, chk_ok, drop_end, push_done;
	logic [CW-1:0] need;
	logic          wr_en, rd_en, load_byte, load_emit;
	logic [PW-1:0] wr_addr;
	byte_t         wr_data, rd_data;

	assign accept    = cmd_valid && cmd_ready;
	assign slot_free = !rsp_valid || rsp_ready;
	assign need      = CW'(LENGTH_BYTES) + CW'(record_length);
	assign no_room   = (record_length > 7'(MAX_RECORD)) || (need > CW'(free_q));
	assign hk_last   = (hk_q == LKW'(LENGTH_BYTES - 1));
	assign chk_ok    = !hdr_hi_q && (hdr_len_q == len_q) && (hdr_len_q <= 7'(MAX_RECORD));
	assign drop_end  = ({1'b0, progress_q} + 8'd1) >= {1'b0, record_length};
	assign push_done = ({1'b0, progress_q} + 8'd1) >= {1'b0, push_len_q};

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (command)
						CMD_PUSH: begin
							priority if (dropping_q)      state_d = S_EMIT;
							else if (progress_q != '0)    state_d = S_DATA_WR;
							else if (no_room)             state_d = S_EMIT;
							else                          state_d = S_HDR_WR;
						end
						CMD_POP, CMD_PEEK: begin
							state_d = (count_q == '0) ? S_EMIT : S_HDR_RD;
						end
						CMD_IGNORE: state_d = S_EMIT;
						default: state_d = S_EMIT;
					endcase
				end
			end
			S_HDR_WR: begin
				if (hk_last) begin
					state_d = (push_len_q == '0) ? S_EMIT : S_DATA_WR;
				end
			end
			S_DATA_WR: state_d = S_EMIT;
			S_HDR_RD:  state_d = S_HDR_ACC;
			S_HDR_ACC: state_d = hk_last ? S_HDR_CHK : S_HDR_RD;
			S_HDR_CHK: state_d = (chk_ok && hdr_len_q != '0) ? S_RD_DATA : S_EMIT;
			S_RD_DATA: begin
				if (slot_free && rem_q == 7'd1) state_d = S_IDLE;
			end
			S_EMIT: begin
				if (slot_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd_ready = (state_q == S_IDLE);
		wr_en     = 1'b0;
		wr_addr   = wp_q;
		wr_data   = byte_q;
		rd_en     = 1'b0;
		load_byte = 1'b0;
		load_emit = 1'b0;
		unique case (state_q)
			S_HDR_WR: begin
				wr_en   = 1'b1;
				wr_data = (hk_q == '0) ? {1'b0, push_len_q} : '0;
			end
			S_DATA_WR: wr_en = 1'b1;
			S_HDR_RD:  rd_en = 1'b1;
			S_HDR_CHK: rd_en = chk_ok && (hdr_len_q != '0);
			S_RD_DATA: begin
				load_byte = slot_free;
				rd_en     = slot_free && (rem_q != 7'd1);
			end
			S_EMIT: load_emit = slot_free;
			default: ;
		endcase
	end

	vlrf_ring #(
		.DEPTH (RING_BYTES),
		.AW    (PW)
	) u_ring (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (cur_q),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			rp_q         <= '0;
			cp_q         <= '0;
			wp_q         <= '0;
			cur_q        <= '0;
			free_q       <= FW'(RING_BYTES);
			count_q      <= '0;
			progress_q   <= '0;
			dropping_q   <= 1'b0;
			push_len_q   <= '0;
			hk_q         <= '0;
			res_status_q <= ST_OK;
		end else begin
			state_q <= state_d;
			if (wr_en) wp_q  <= ring_inc(wp_q);
			if (rd_en) cur_q <= ring_inc(cur_q);
			unique case (state_q)
				S_IDLE: begin
					hk_q <= '0;
					if (accept) begin
						res_status_q <= ST_OK;
						unique case (command)
							CMD_PUSH: begin
								priority if (dropping_q) begin
									res_status_q <= ST_NOROOM;
									if (drop_end) begin
										dropping_q <= 1'b0;
										progress_q <= '0;
									end else begin
										progress_q <= progress_q + 7'd1;
									end
								end else if (progress_q != '0) begin
								end else if (no_room) begin
									res_status_q <= ST_NOROOM;
									if (record_length > 7'd1) begin
										dropping_q <= 1'b1;
										progress_q <= 7'd1;
									end
								end else begin
									free_q     <= free_q - FW'(need);
									wp_q       <= cp_q;
									push_len_q <= record_length;
								end
							end
							CMD_POP, CMD_PEEK: begin
								if (count_q == '0) res_status_q <= ST_EMPTY;
								cur_q <= rp_q;
							end
							CMD_IGNORE: ;
							default: ;
						endcase
					end
				end
				S_HDR_WR: begin
					hk_q <= hk_q + LKW'(1);
					if (hk_last && push_len_q == '0) begin
						cp_q    <= ring_inc(wp_q);
						count_q <= count_q + FW'(1);
					end
				end
				S_DATA_WR: begin
					if (push_done) begin
						cp_q       <= ring_inc(wp_q);
						count_q    <= count_q + FW'(1);
						progress_q <= '0;
					end else begin
						progress_q <= progress_q + 7'd1;
					end
				end
				S_HDR_ACC: begin
					hk_q <= hk_q + LKW'(1);
				end
				S_HDR_CHK: begin
					if (!chk_ok) begin
						res_status_q <= ST_MISMATCH;
					end else if (pop_q) begin
						free_q  <= free_q + FW'(LENGTH_BYTES) + FW'(hdr_len_q);
						count_q <= count_q - FW'(1);
						if (hdr_len_q == '0) rp_q <= cur_q;
					end
				end
				S_RD_DATA: begin
					if (load_byte && rem_q == 7'd1 && pop_q) rp_q <= cur_q;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_q <= data_byte;
			len_q  <= record_length;
			pop_q  <= (command == CMD_POP);
		end
		if (state_q == S_HDR_ACC) begin
			if (hk_q == '0) begin
				hdr_len_q <= rd_data[6:0];
				hdr_hi_q  <= rd_data[7];
			end else begin
				hdr_hi_q  <= hdr_hi_q | (|rd_data);
			end
		end
		if (state_q == S_HDR_CHK) begin
			rem_q <= hdr_len_q;
		end else if (load_byte) begin
			rem_q <= rem_q - 7'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (load_byte || load_emit) begin
			rsp_valid <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_byte || load_emit) begin
			status     <= load_byte ? ST_OK : res_status_q;
			out_byte   <= load_byte ? rd_data : '0;
			byte_valid <= load_byte;
			last       <= load_emit || (rem_q == 7'd1);
			empty_flag <= (count_q == '0);
			free_bytes <= 9'(free_q);
		end
	end

	`VLRF_ASSERT_NOW(a_free_range, 1'b1, free_q <= FW'(RING_BYTES))
	`VLRF_ASSERT_NOW(a_empty_ptrs, state_q == S_IDLE && count_q == '0, rp_q == cp_q)
	`VLRF_ASSERT_NOW(a_byte_ok, rsp_valid && byte_valid, status == ST_OK)
	`VLRF_ASSERT_NEXT(a_busy_after_accept, accept, !cmd_ready)

endmodule

### rtl/vlrf_ring.sv
// Byte ring store: one write port, one read port with registered read data.
module vlrf_ring #(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  logic           clk,
	input  logic           wr_en,
	input  logic [AW-1:0]  wr_addr,
	input  vlrf_pkg::byte_t wr_data,
	input  logic           rd_en,
	input  logic [AW-1:0]  rd_addr,
	output vlrf_pkg::byte_t rd_data
);
	import vlrf_pkg::*;

	byte_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
